FILE: rtl/core/ptrt_pkg.sv
// ptrt_pkg: types and constants shared by the periodic task release table
// holds the command and result items, the table entry layout and the sequencer states
// no dependencies
package ptrt_pkg;

    localparam int RESULT_LIMIT = 16;

    typedef enum logic [1:0] {
        FN_TICK     = 2'd0,
        FN_ADD      = 2'd1,
        FN_REMOVE   = 2'd2,
        FN_DISPATCH = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        K_RUN       = 3'd0,
        K_ADDED     = 3'd1,
        K_FULL      = 3'd2,
        K_DUP       = 3'd3,
        K_REMOVED   = 3'd4,
        K_NOT_FOUND = 3'd5,
        K_NONE      = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        CFG_TICK_STEP  = 2'd0,
        CFG_MIN_PERIOD = 2'd1,
        CFG_MAX_PERIOD = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  task_id;
        logic [19:0] period_us;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  task_id_res;
        logic [19:0] period_used;
        logic [4:0]  task_count;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [7:0]  id;
        logic [19:0] period;
        logic        rdy;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EV,
        S_DIV,
        S_SHIFT,
        S_SHWR,
        S_FIN
    } t_state;

endpackage

FILE: rtl/core/ptrt_ram.sv
// ptrt_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module ptrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH>1?DEPTH:2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH>1?DEPTH:2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/core/ptrt_mod.sv
// ptrt_mod: bit-serial remainder unit, 32-bit time modulo 20-bit period
// one dividend bit per cycle; no dependencies
module ptrt_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [19:0] i_divisor,
    output logic        o_done,
    output logic        o_rem_zero
);
    logic [19:0] r_rem;
    logic [31:0] r_dv;
    logic [19:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [20:0] trial;
    logic [20:0] diff;
    logic [19:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dv[31]};
        diff  = trial - {1'b0, r_div};
        n_rem = (trial >= {1'b0, r_div}) ? diff[19:0] : trial[19:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dv   <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dv  <= {r_dv[30:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy     <= 1'b0;
                    o_done     <= 1'b1;
                    o_rem_zero <= (n_rem == 20'd0);
                end
            end
        end
    end
endmodule

FILE: rtl/core/periodic_task_release_table_top.sv
// periodic task release table: table in one ram, walked by a sequencer
// tick walks every entry and runs the serial remainder on each waiting entry with a nonzero period
// add, remove and dispatch walk the entries (remove also moves the entries above it down); one at a time
// results are strobed for one cycle each, the receiver cannot stall
// sync active low reset clears control, time and entry count and loads config defaults; ram needs no clearing pass
module periodic_task_release_table_top
    import ptrt_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_cmd        i_cmd,
    output logic        o_res_valid,
    output t_res        o_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = $bits(t_entry);
    localparam logic [CW-1:0] MAXC = CW'(MAX_ENTRIES);

    // configuration registers
    logic [9:0]  r_step;
    logic [19:0] r_min, r_max;

    // control state
    t_state       r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [31:0]  r_time;
    t_cmd         r_cmd;
    logic [4:0]   r_found, n_found;
    logic         r_pend_v, n_pend_v;
    logic [7:0]   r_pend_id, n_pend_id;
    t_entry       r_ent;

    // ram ports
    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    t_entry        ram_wdata, ram_rdata;

    // remainder unit
    logic div_start, div_done, div_zero;

    // result being emitted this cycle
    logic        emit;
    t_kind       e_kind;
    logic [7:0]  e_id;
    logic [19:0] e_per;
    logic        e_last;

    logic [CW-1:0] nxt_idx;
    logic          at_end;
    logic [19:0]   clamp_hi, clamp;
    logic [CW+4:0] cnt_ext;
    logic          accept;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;

    ptrt_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // divisor taken straight from the entry read, sampled on the start cycle
    ptrt_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_time),
        .i_divisor  (ram_rdata.period),
        .o_done     (div_done),
        .o_rem_zero (div_zero)
    );

    // period clamp: cap at max first, then raise to min
    always_comb begin
        clamp_hi = (r_cmd.period_us > r_max) ? r_max : r_cmd.period_us;
        clamp    = (clamp_hi < r_min) ? r_min : clamp_hi;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_found   = r_found;
        n_pend_v  = r_pend_v;
        n_pend_id = r_pend_id;
        ram_we    = 1'b0;
        ram_waddr = r_idx[IW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_idx[IW-1:0];
        div_start = 1'b0;
        emit      = 1'b0;
        e_kind    = K_NONE;
        e_id      = r_cmd.task_id;
        e_per     = 20'd0;
        e_last    = 1'b1;
        nxt_idx   = r_idx + CW'(1);
        at_end    = (nxt_idx == r_count);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx     = '0;
                    n_found   = '0;
                    n_pend_v  = 1'b0;
                    if (i_cmd.func == FN_ADD && r_count >= MAXC) begin
                        emit    = 1'b1;
                        e_kind  = K_FULL;
                        e_id    = i_cmd.task_id;
                        n_state = S_IDLE;
                    end else if (r_count == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            // read issued at r_idx, data arrives next cycle
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                n_state = at_end ? S_FIN : S_RD;
                n_idx   = nxt_idx;
                case (t_func'(r_cmd.func))
                    FN_TICK: begin
                        if (!ram_rdata.rdy && ram_rdata.period != 20'd0) begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                            n_idx     = r_idx;
                        end
                    end
                    FN_ADD: begin
                        if (ram_rdata.id == r_cmd.task_id) begin
                            emit    = 1'b1;
                            e_kind  = K_DUP;
                            n_state = S_IDLE;
                        end
                    end
                    FN_REMOVE: begin
                        if (ram_rdata.id == r_cmd.task_id) begin
                            n_state = S_SHIFT;
                            n_idx   = r_idx;
                        end
                    end
                    FN_DISPATCH: begin
                        if (ram_rdata.rdy) begin
                            ram_we        = 1'b1;
                            ram_wdata.rdy = 1'b0;
                            // hold each find back one step so last is known
                            if (r_pend_v) begin
                                emit   = 1'b1;
                                e_kind = K_RUN;
                                e_id   = r_pend_id;
                                e_last = 1'b0;
                            end
                            n_pend_v  = 1'b1;
                            n_pend_id = ram_rdata.id;
                            n_found   = r_found + 5'd1;
                            if (n_found == 5'(RESULT_LIMIT)) begin
                                n_state = S_FIN;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    if (div_zero) begin
                        ram_we        = 1'b1;
                        ram_wdata     = r_ent;
                        ram_wdata.rdy = 1'b1;
                    end
                    n_idx   = nxt_idx;
                    n_state = at_end ? S_FIN : S_RD;
                end
            end
            // compaction: read entry above, then write it one place down
            S_SHIFT: begin
                ram_raddr = nxt_idx[IW-1:0];
                if (at_end) begin
                    n_count = r_count - CW'(1);
                    emit    = 1'b1;
                    e_kind  = K_REMOVED;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                ram_raddr = nxt_idx[IW-1:0];
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_idx     = nxt_idx;
                n_state   = S_SHIFT;
            end
            S_FIN: begin
                n_state = S_IDLE;
                case (t_func'(r_cmd.func))
                    FN_ADD: begin
                        ram_we           = 1'b1;
                        ram_waddr        = r_count[IW-1:0];
                        ram_wdata.id     = r_cmd.task_id;
                        ram_wdata.period = clamp;
                        ram_wdata.rdy    = 1'b1;
                        n_count          = r_count + CW'(1);
                        emit             = 1'b1;
                        e_kind           = K_ADDED;
                        e_per            = clamp;
                    end
                    FN_REMOVE: begin
                        emit   = 1'b1;
                        e_kind = K_NOT_FOUND;
                    end
                    FN_DISPATCH: begin
                        emit     = 1'b1;
                        n_pend_v = 1'b0;
                        if (r_pend_v) begin
                            e_kind = K_RUN;
                            e_id   = r_pend_id;
                        end else begin
                            e_kind = K_NONE;
                            e_id   = 8'd0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign cnt_ext = {5'd0, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_time      <= '0;
            r_found     <= '0;
            r_pend_v    <= 1'b0;
            r_step      <= 10'd10;
            r_min       <= 20'd1000;
            r_max       <= 20'd100000;
            o_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_pend_v    <= n_pend_v;
            o_res_valid <= emit;
            if (accept && i_cmd.func == FN_TICK) begin
                r_time <= r_time + {22'd0, r_step};
            end
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_TICK_STEP:  r_step <= i_cfg_data[9:0];
                    CFG_MIN_PERIOD: r_min  <= i_cfg_data;
                    CFG_MAX_PERIOD: r_max  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend_id <= n_pend_id;
        if (accept) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_EV) begin
            r_ent <= ram_rdata;
        end
        if (emit) begin
            o_res.kind        <= e_kind;
            o_res.task_id_res <= e_id;
            o_res.period_used <= e_per;
            o_res.task_count  <= cnt_ext[4:0];
            o_res.last        <= e_last;
        end
    end

    // entry count never exceeds the table
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAXC) else $error("entry count over table size");

    // a result that is not the last of its item is always a run result
    a_notlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last) |-> (o_res.kind == K_RUN))
        else $error("non-final result of wrong kind");

    // the remainder unit only finishes while the sequencer waits for it
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV)) else $error("stray remainder done");

    // an accepted item makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !(i_cmd.func == FN_ADD && r_count >= MAXC)) |=> busy)
        else $error("accepted item left block idle");

endmodule
